// ----- src/dmcr_pkg.sv -----
// Shared types, constants and saturation helpers for the dual Monod cell rate unit.
`timescale 1ns / 1ps
package dmcr_pkg;

  localparam int VALUE_WIDTH   = 48;
  localparam int FRACTION_BITS = 32;
  localparam int HALF_W        = (VALUE_WIDTH + 1) / 2;
  localparam int PART_W        = 2 * HALF_W;
  localparam int SUM_W         = 4 * HALF_W;
  localparam int PROD_W        = 2 * VALUE_WIDTH;
  localparam int RATIO_W       = FRACTION_BITS + 1;
  localparam int REM_W         = VALUE_WIDTH + 2;
  localparam int DIV_STEPS     = FRACTION_BITS + 1;
  localparam int PIPE_DEPTH    = DIV_STEPS + 9;
  localparam int CFG_IDX_W     = 3;

  typedef logic [VALUE_WIDTH-1:0]        value_t;
  typedef logic signed [VALUE_WIDTH-1:0] svalue_t;
  typedef logic [PROD_W-1:0]             prod_t;
  typedef logic [RATIO_W-1:0]            ratio_t;
  typedef logic [HALF_W-1:0]             half_t;
  typedef logic [PART_W-1:0]             part_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_GROWTH   = CFG_IDX_W'(0),
    CFG_INV_YIELD    = CFG_IDX_W'(1),
    CFG_SUC_AFFINITY = CFG_IDX_W'(2),
    CFG_OXY_AFFINITY = CFG_IDX_W'(3),
    CFG_MAINTENANCE  = CFG_IDX_W'(4),
    CFG_DECAY        = CFG_IDX_W'(5),
    CFG_REACT_EN     = CFG_IDX_W'(6),
    CFG_GROW_EN      = CFG_IDX_W'(7)
  } cfg_idx_e;

  localparam value_t VMASK = '1;
  localparam value_t SMAX  = VMASK >> 1;
  localparam value_t SMIN  = ~SMAX;
  localparam value_t ONE   = value_t'(64'd1 << FRACTION_BITS);
  localparam value_t K_O2  =
    value_t'(((64'd399 << FRACTION_BITS) + 64'd500) / 64'd1000);
  localparam value_t K_CO2 =
    value_t'(((64'd2 << FRACTION_BITS) + 64'd5) / 64'd10);

  // Per-item sideband that rides along the pipeline.
  typedef struct packed {
    value_t density;
    logic   ghost;
    logic   last;
  } side_t;

  // Drop the fraction bits of a product and clamp to the unsigned range.
  function automatic value_t fix_sat(prod_t p);
    prod_t sh;
    sh = p >> FRACTION_BITS;
    if (sh > prod_t'(VMASK)) begin
      return VMASK;
    end
    return sh[VALUE_WIDTH-1:0];
  endfunction

  // Negate a magnitude, clamping at the most negative code.
  function automatic svalue_t neg_sat(prod_t mag);
    value_t neg;
    neg = value_t'(0) - mag[VALUE_WIDTH-1:0];
    if (mag > prod_t'(SMAX) + prod_t'(1)) begin
      return svalue_t'(SMIN);
    end
    return svalue_t'(neg);
  endfunction

  // Clamp a magnitude to the largest positive code.
  function automatic svalue_t pos_sat(prod_t mag);
    if (mag > prod_t'(SMAX)) begin
      return svalue_t'(SMAX);
    end
    return svalue_t'(mag[VALUE_WIDTH-1:0]);
  endfunction

endpackage

// ----- src/dmcr_in_if.sv -----
// Cell input channel: valid, ready and the cell fields.
`timescale 1ns / 1ps
interface dmcr_in_if;
  import dmcr_pkg::*;
  logic   valid;
  logic   ready;
  value_t sucrose_conc;
  value_t oxygen_conc;
  value_t biomass_density;
  logic   ghost_cell;
  logic   last_cell;

  modport source (output valid, sucrose_conc, oxygen_conc, biomass_density, ghost_cell,
                  last_cell, input ready);
  modport sink (input valid, sucrose_conc, oxygen_conc, biomass_density, ghost_cell,
                last_cell, output ready);
endinterface

// ----- src/dmcr_out_if.sv -----
// Rate output channel: valid, ready and the result fields.
`timescale 1ns / 1ps
interface dmcr_out_if;
  import dmcr_pkg::*;
  logic    valid;
  logic    ready;
  svalue_t sucrose_delta;
  svalue_t oxygen_delta;
  svalue_t co2_delta;
  svalue_t net_growth;
  logic    last_out;

  modport source (output valid, sucrose_delta, oxygen_delta, co2_delta, net_growth,
                  last_out, input ready);
  modport sink (input valid, sucrose_delta, oxygen_delta, co2_delta, net_growth,
                last_out, output ready);
endinterface

// ----- src/dmcr_ratio.sv -----
// Pipelined restoring divider for the Monod ratio x * 2^F / (k + x).
`timescale 1ns / 1ps
module dmcr_ratio (
  input  logic            clk_i,
  input  logic            ce_i,
  input  dmcr_pkg::value_t x_i,
  input  dmcr_pkg::value_t k_i,
  output dmcr_pkg::ratio_t ratio_o
);
  import dmcr_pkg::*;

  logic [REM_W-1:0]       rem_q  [DIV_STEPS];
  logic [VALUE_WIDTH:0]   den_q  [DIV_STEPS];
  ratio_t                 quo_q  [DIV_STEPS];
  logic                   zero_q [DIV_STEPS];

  logic [VALUE_WIDTH:0]   den0;
  logic [REM_W-1:0]       rem0;
  logic                   ge0;

  // The quotient never exceeds 2^F, so the top step compares x itself.
  assign den0 = {1'b0, x_i} + {1'b0, k_i};
  assign rem0 = REM_W'(x_i);
  assign ge0  = rem0 >= REM_W'(den0);

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      den_q[0]  <= den0;
      zero_q[0] <= (den0 == '0);
      rem_q[0]  <= ge0 ? rem0 - REM_W'(den0) : rem0;
      quo_q[0]  <= {ge0, FRACTION_BITS'(0)};
    end
  end

  for (genvar i = 1; i < DIV_STEPS; i++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;
    assign trial = rem_q[i-1] << 1;
    assign ge    = trial >= REM_W'(den_q[i-1]);

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        den_q[i]  <= den_q[i-1];
        zero_q[i] <= zero_q[i-1];
        rem_q[i]  <= ge ? trial - REM_W'(den_q[i-1]) : trial;
        quo_q[i]  <= quo_q[i-1] | (RATIO_W'(ge) << (FRACTION_BITS - i));
      end
    end
  end

  assign ratio_o = zero_q[DIV_STEPS-1] ? '0 : quo_q[DIV_STEPS-1];

endmodule

// ----- src/dmcr_mul.sv -----
// Two-stage multiplier built from four half-width partial products.
`timescale 1ns / 1ps
module dmcr_mul (
  input  logic             clk_i,
  input  logic             ce_i,
  input  dmcr_pkg::value_t a_i,
  input  dmcr_pkg::value_t b_i,
  output dmcr_pkg::prod_t  prod_o
);
  import dmcr_pkg::*;

  half_t a_lo, a_hi, b_lo, b_hi;
  part_t pp_q [4];
  prod_t prod_q;
  logic [SUM_W-1:0] sum;

  assign a_lo = a_i[HALF_W-1:0];
  assign a_hi = HALF_W'(a_i >> HALF_W);
  assign b_lo = b_i[HALF_W-1:0];
  assign b_hi = HALF_W'(b_i >> HALF_W);

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      pp_q[0] <= PART_W'(a_lo) * PART_W'(b_lo);
      pp_q[1] <= PART_W'(a_lo) * PART_W'(b_hi);
      pp_q[2] <= PART_W'(a_hi) * PART_W'(b_lo);
      pp_q[3] <= PART_W'(a_hi) * PART_W'(b_hi);
    end
  end

  assign sum = SUM_W'(pp_q[0]) + (SUM_W'(pp_q[1]) << HALF_W)
             + (SUM_W'(pp_q[2]) << HALF_W) + (SUM_W'(pp_q[3]) << (2 * HALF_W));

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      prod_q <= sum[PROD_W-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- src/dual_monod_cell_rates_unit.sv -----
// Top level of the dual Monod cell rate unit: configuration, pipeline and output stage.
`timescale 1ns / 1ps
// The unit takes one grid cell per transfer and returns one rate result per cell, in
// order, at a sustained rate of one cell per clock while the output does not stall. Values
// are Q16.32. The two Monod ratios come from FRACTION_BITS + 1 divider stages that resolve
// one quotient bit each, followed by four chained multiplier levels of two stages each,
// one add stage and the output register. The whole pipeline advances together whenever
// the output register is empty or being drained, so a stall on the output side holds
// every cell in place and input ready drops in the same cycle. Configuration registers
// are written through the plain write port and must only change while no cell is in
// flight.
module dual_monod_cell_rates_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dmcr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  dmcr_pkg::value_t                  cfg_data_i,
  dmcr_in_if.sink                           cell_i,
  dmcr_out_if.source                        rate_o
);
  import dmcr_pkg::*;

  // Configuration registers.
  value_t mu_q, iy_q, ks_q, ko_q, maint_q, decay_q;
  logic   react_q, grow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q    <= '0;
      iy_q    <= ONE;
      ks_q    <= ONE;
      ko_q    <= ONE;
      maint_q <= '0;
      decay_q <= '0;
      react_q <= 1'b1;
      grow_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_GROWTH:   mu_q    <= cfg_data_i;
        CFG_INV_YIELD:    iy_q    <= cfg_data_i;
        CFG_SUC_AFFINITY: ks_q    <= cfg_data_i;
        CFG_OXY_AFFINITY: ko_q    <= cfg_data_i;
        CFG_MAINTENANCE:  maint_q <= cfg_data_i;
        CFG_DECAY:        decay_q <= cfg_data_i;
        CFG_REACT_EN:     react_q <= cfg_data_i[0];
        CFG_GROW_EN:      grow_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Global advance: the output register is free or is transferring this cycle.
  logic out_vld_q;
  logic ce;
  assign ce           = !out_vld_q || rate_o.ready;
  assign cell_i.ready = ce;

  // Valid bits and sideband, aligned with the datapath register at the same index.
  logic  vld_q  [PIPE_DEPTH];
  side_t side_q [PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (ce) begin
      vld_q[0] <= cell_i.valid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      side_q[0] <= '{density: cell_i.biomass_density, ghost: cell_i.ghost_cell,
                     last: cell_i.last_cell};
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Monod ratios for sucrose and oxygen.
  ratio_t rs, ro;

  dmcr_ratio u_ratio_suc (
    .clk_i   (clk_i),
    .ce_i    (ce),
    .x_i     (cell_i.sucrose_conc),
    .k_i     (ks_q),
    .ratio_o (rs)
  );

  dmcr_ratio u_ratio_oxy (
    .clk_i   (clk_i),
    .ce_i    (ce),
    .x_i     (cell_i.oxygen_conc),
    .k_i     (ko_q),
    .ratio_o (ro)
  );

  // First products: mu * rS and maintenance * rO.
  prod_t p_mu, p_maint;

  dmcr_mul u_mul_mu (
    .clk_i (clk_i), .ce_i (ce), .a_i (mu_q), .b_i (VALUE_WIDTH'(rs)), .prod_o (p_mu)
  );

  dmcr_mul u_mul_maint (
    .clk_i (clk_i), .ce_i (ce), .a_i (maint_q), .b_i (VALUE_WIDTH'(ro)), .prod_o (p_maint)
  );

  // The oxygen ratio waits for the first growth product, the maintenance term for the second.
  ratio_t ro_q  [2];
  value_t mnt_q [2];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      ro_q[0]  <= ro;
      ro_q[1]  <= ro_q[0];
      mnt_q[0] <= fix_sat(p_maint);
      mnt_q[1] <= mnt_q[0];
    end
  end

  prod_t p_grow;

  dmcr_mul u_mul_grow (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .a_i    (fix_sat(p_mu)),
    .b_i    (VALUE_WIDTH'(ro_q[1])),
    .prod_o (p_grow)
  );

  // Growth, maintenance and their saturated sum.
  value_t g_q, m_q, sum_q;
  value_t g_d;
  logic [VALUE_WIDTH:0] gm;

  assign g_d = fix_sat(p_grow);
  assign gm  = {1'b0, g_d} + {1'b0, mnt_q[1]};

  always_ff @(posedge clk_i) begin
    if (ce) begin
      g_q   <= g_d;
      m_q   <= mnt_q[1];
      sum_q <= gm[VALUE_WIDTH] ? VMASK : gm[VALUE_WIDTH-1:0];
    end
  end

  // Net growth is g - m - decay, clamped to the signed range, then delayed to the output.
  // The loss keeps its carry bit, so a loss past full scale still yields the exact
  // difference before clamping.
  logic [VALUE_WIDTH:0] loss;
  logic [VALUE_WIDTH:0] gx;
  svalue_t net_d;
  svalue_t net_q [4];

  assign loss = {1'b0, m_q} + {1'b0, decay_q};
  assign gx   = {1'b0, g_q};

  always_comb begin
    if (gx >= loss) begin
      net_d = pos_sat(PROD_W'(gx - loss));
    end else begin
      net_d = neg_sat(PROD_W'(loss - gx));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      net_q[0] <= net_d;
      for (int i = 1; i < 4; i++) begin
        net_q[i] <= net_q[i-1];
      end
    end
  end

  // Yield and stoichiometric scaling.
  prod_t p_suc_s, p_oxy_s, p_co2_s;

  dmcr_mul u_mul_suc_s (
    .clk_i (clk_i), .ce_i (ce), .a_i (iy_q), .b_i (g_q), .prod_o (p_suc_s)
  );

  dmcr_mul u_mul_oxy_s (
    .clk_i (clk_i), .ce_i (ce), .a_i (K_O2), .b_i (sum_q), .prod_o (p_oxy_s)
  );

  dmcr_mul u_mul_co2_s (
    .clk_i (clk_i), .ce_i (ce), .a_i (K_CO2), .b_i (sum_q), .prod_o (p_co2_s)
  );

  // Scale by biomass density; the density is taken from the sideband at this stage.
  prod_t p_suc, p_oxy, p_co2;
  value_t dens;

  assign dens = side_q[DIV_STEPS+6].density;

  dmcr_mul u_mul_suc (
    .clk_i (clk_i), .ce_i (ce), .a_i (fix_sat(p_suc_s)), .b_i (dens), .prod_o (p_suc)
  );

  dmcr_mul u_mul_oxy (
    .clk_i (clk_i), .ce_i (ce), .a_i (fix_sat(p_oxy_s)), .b_i (dens), .prod_o (p_oxy)
  );

  dmcr_mul u_mul_co2 (
    .clk_i (clk_i), .ce_i (ce), .a_i (fix_sat(p_co2_s)), .b_i (dens), .prod_o (p_co2)
  );

  // Output register. Ghost cells and a disabled reaction give zero sucrose, oxygen and CO2 deltas.
  logic    react_on;
  svalue_t suc_out_q, oxy_out_q, co2_out_q, net_out_q;
  logic    last_out_q;

  assign react_on = react_q && !side_q[PIPE_DEPTH-1].ghost;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ce) begin
      out_vld_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      suc_out_q  <= react_on ? neg_sat(p_suc >> FRACTION_BITS) : '0;
      oxy_out_q  <= react_on ? neg_sat(p_oxy >> FRACTION_BITS) : '0;
      co2_out_q  <= react_on ? pos_sat(p_co2 >> FRACTION_BITS) : '0;
      net_out_q  <= grow_q ? net_q[3] : '0;
      last_out_q <= side_q[PIPE_DEPTH-1].last;
    end
  end

  assign rate_o.valid         = out_vld_q;
  assign rate_o.sucrose_delta = suc_out_q;
  assign rate_o.oxygen_delta  = oxy_out_q;
  assign rate_o.co2_delta     = co2_out_q;
  assign rate_o.net_growth    = net_out_q;
  assign rate_o.last_out      = last_out_q;

endmodule
